// File: design/vang_pkg.sv
// vang_pkg: shared types and constants of the vector angle pipeline
// holds the side-band struct, status codes, cross-term pairs and the arctangent table
// no dependencies
`default_nettype none
package vang_pkg;
    localparam int TURN_FRAC    = 30;
    localparam int CORDIC_STEPS = 31;
    localparam int SUM_W        = 66;
    localparam int AD_W         = 33;
    localparam int ROOT_W       = 33;
    localparam int XY_W         = 40;
    localparam int Z_W          = 33;

    localparam logic [Z_W-1:0] PI_Q30      = 33'd3373259426;
    localparam logic [Z_W-1:0] HALF_PI_Q30 = 33'd1686629713;

    localparam int PAIR_A [6] = '{0, 0, 0, 1, 1, 2};
    localparam int PAIR_B [6] = '{1, 2, 3, 2, 3, 3};

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_P_ZERO = 2'd1,
        ST_Q_ZERO = 2'd2,
        ST_CLAMP  = 2'd3
    } t_status;

    typedef struct packed {
        logic    valid;
        logic    neg;
        t_status status;
    } t_side;

    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000008;
            28: v = 32'h00000004;
            29: v = 32'h00000002;
            30: v = 32'h00000001;
            default: v = 32'h0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// File: design/vang_front.sv
// vang_front: input register, narrowing, zero check, dot product and squared cross terms
// six register stages; depends on vang_pkg
`default_nettype none
module vang_front #(
    parameter int CB = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic signed [CB-1:0]          i_p [4],
    input  wire logic signed [CB-1:0]          i_q [4],
    output logic [vang_pkg::SUM_W-1:0]         o_sum,
    output logic [vang_pkg::AD_W-1:0]          o_ad,
    output vang_pkg::t_side                    o_side
);
    import vang_pkg::*;

    localparam int NK = (CB > 16) ? CB - 16 : 0;

    function automatic logic fits(input logic signed [CB-1:0] v, input int k);
        logic signed [CB-1:0] t;
        t = v >>> k;
        return (t <= 32767) && (t >= -32768);
    endfunction

    function automatic logic signed [15:0] narrow_one(input logic signed [CB-1:0] v,
                                                      input int k);
        logic signed [CB-1:0] t;
        t = v >>> k;
        return 16'(t);
    endfunction

    // stage a: raw inputs
    logic                 r_va;
    logic signed [CB-1:0] r_p_raw [4];
    logic signed [CB-1:0] r_q_raw [4];

    // stage b: narrowed vectors
    t_side              r_sb, n_sb;
    logic signed [15:0] r_pn [4], n_pn [4];
    logic signed [15:0] r_qn [4], n_qn [4];

    // stage c: products
    t_side              r_sc;
    logic signed [31:0] r_pd [4];
    logic signed [31:0] r_xa [6];
    logic signed [31:0] r_xb [6];

    // stage d: dot product and cross terms
    t_side              r_sd;
    logic signed [33:0] r_d, n_d;
    logic signed [32:0] r_c [6];

    // stage e: magnitudes and squares
    t_side              r_se;
    logic [AD_W-1:0]    r_ad_e;
    logic [63:0]        r_sq [6];

    // stage f: sum of squares
    t_side              r_sf;
    logic [AD_W-1:0]    r_ad_f;
    logic [SUM_W-1:0]   r_sum, n_sum;

    always_comb begin
        int  kp;
        int  kq;
        logic okp;
        logic okq;
        logic pz;
        logic qz;
        kp = 0;
        kq = 0;
        for (int s = NK; s >= 0; s--) begin
            okp = 1'b1;
            okq = 1'b1;
            for (int e = 0; e < 4; e++) begin
                okp = okp & fits(r_p_raw[e], s);
                okq = okq & fits(r_q_raw[e], s);
            end
            if (okp) kp = s;
            if (okq) kq = s;
        end
        pz = 1'b1;
        qz = 1'b1;
        for (int e = 0; e < 4; e++) begin
            n_pn[e] = narrow_one(r_p_raw[e], kp);
            n_qn[e] = narrow_one(r_q_raw[e], kq);
            if (r_p_raw[e] != '0) pz = 1'b0;
            if (r_q_raw[e] != '0) qz = 1'b0;
        end
        n_sb.valid  = r_va;
        n_sb.neg    = 1'b0;
        n_sb.status = pz ? ST_P_ZERO : (qz ? ST_Q_ZERO : ST_OK);
    end

    always_comb begin
        n_d = '0;
        for (int e = 0; e < 4; e++) begin
            n_d = n_d + 34'(r_pd[e]);
        end
        n_sum = '0;
        for (int j = 0; j < 6; j++) begin
            n_sum = n_sum + SUM_W'(r_sq[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va     <= 1'b0;
            r_sb     <= '0;
            r_sc     <= '0;
            r_sd     <= '0;
            r_se     <= '0;
            r_sf     <= '0;
        end else begin
            r_va     <= i_valid;
            r_sb     <= n_sb;
            r_sc     <= r_sb;
            r_sd     <= r_sc;
            r_se.valid  <= r_sd.valid;
            r_se.status <= r_sd.status;
            r_se.neg    <= r_d[33];
            r_sf     <= r_se;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [31:0] m;
        r_p_raw <= i_p;
        r_q_raw <= i_q;
        r_pn    <= n_pn;
        r_qn    <= n_qn;
        for (int e = 0; e < 4; e++) begin
            r_pd[e] <= r_pn[e] * r_qn[e];
        end
        for (int j = 0; j < 6; j++) begin
            r_xa[j] <= r_pn[PAIR_A[j]] * r_qn[PAIR_B[j]];
            r_xb[j] <= r_pn[PAIR_B[j]] * r_qn[PAIR_A[j]];
            r_c[j]  <= 33'(r_xa[j]) - 33'(r_xb[j]);
            m        = r_c[j][32] ? 32'(-r_c[j]) : 32'(r_c[j]);
            r_sq[j] <= 64'(m) * 64'(m);
        end
        r_d    <= n_d;
        r_ad_e <= r_d[33] ? AD_W'(-r_d) : AD_W'(r_d);
        r_ad_f <= r_ad_e;
        r_sum  <= n_sum;
    end

    assign o_sum  = r_sum;
    assign o_ad   = r_ad_f;
    assign o_side = r_sf;
endmodule
`default_nettype wire

// File: design/vang_norm.sv
// vang_norm: scales the squared sine term and the dot magnitude before the square root
// leading-zero count stage then shift stage; depends on vang_pkg
`default_nettype none
module vang_norm (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [vang_pkg::SUM_W-1:0] i_sum,
    input  wire logic [vang_pkg::AD_W-1:0]  i_ad,
    input  wire vang_pkg::t_side            i_side,
    output logic [vang_pkg::SUM_W-1:0]      o_rad,
    output logic [vang_pkg::AD_W-1:0]       o_ad,
    output vang_pkg::t_side                 o_side
);
    import vang_pkg::*;

    t_side            r_s1, r_s2;
    logic [SUM_W-1:0] r_sum1;
    logic [AD_W-1:0]  r_ad1;
    logic [5:0]       r_k, n_k;
    logic [SUM_W-1:0] r_rad;
    logic [AD_W-1:0]  r_ad2;

    always_comb begin
        int lz;
        int lza;
        int klo;
        int kad;
        lz = 64;
        for (int b = 0; b < 64; b++) begin
            if (i_sum[b]) lz = 63 - b;
        end
        lza = AD_W;
        for (int b = 0; b < AD_W; b++) begin
            if (i_ad[b]) lza = AD_W - 1 - b;
        end
        klo = (i_sum[63:0] == '0) ? 63 : (lz >> 1);
        kad = (i_ad == '0) ? 63 : ((lza > 0) ? lza - 1 : 0);
        if (i_sum[SUM_W-1:64] != '0) begin
            n_k = '0;
        end else begin
            n_k = (klo < kad) ? 6'(klo) : 6'(kad);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else begin
            r_s1 <= i_side;
            r_s2 <= r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum1 <= i_sum;
        r_ad1  <= i_ad;
        r_k    <= n_k;
        r_rad  <= {r_sum1[SUM_W-1:64], r_sum1[63:0] << {r_k, 1'b0}};
        r_ad2  <= r_ad1 << r_k;
    end

    assign o_rad  = r_rad;
    assign o_ad   = r_ad2;
    assign o_side = r_s2;
endmodule
`default_nettype wire

// File: design/vang_sqrt.sv
// vang_sqrt: pipelined restoring integer square root, one result bit per stage
// depends on vang_pkg
`default_nettype none
module vang_sqrt (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [vang_pkg::SUM_W-1:0] i_rad,
    input  wire logic [vang_pkg::AD_W-1:0]  i_ad,
    input  wire vang_pkg::t_side            i_side,
    output logic [vang_pkg::ROOT_W-1:0]     o_root,
    output logic [vang_pkg::AD_W-1:0]       o_ad,
    output vang_pkg::t_side                 o_side
);
    import vang_pkg::*;

    localparam int REM_W = 36;

    logic [SUM_W-1:0]  w_rad  [ROOT_W+1];
    logic [REM_W-1:0]  w_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] w_root [ROOT_W+1];
    logic [AD_W-1:0]   w_ad   [ROOT_W+1];
    t_side             w_side [ROOT_W+1];

    assign w_rad[0]  = i_rad;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_ad[0]   = i_ad;
    assign w_side[0] = i_side;

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        logic [SUM_W-1:0]  r_rad;
        logic [REM_W-1:0]  r_rem, n_rem;
        logic [ROOT_W-1:0] r_root, n_root;
        logic [AD_W-1:0]   r_ad;
        t_side             r_side;

        always_comb begin
            logic [REM_W-1:0] remn;
            logic [REM_W-1:0] trial;
            remn  = {w_rem[j][REM_W-3:0], w_rad[j][SUM_W-1:SUM_W-2]};
            trial = REM_W'({w_root[j], 2'b01});
            if (remn >= trial) begin
                n_rem  = remn - trial;
                n_root = {w_root[j][ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = remn;
                n_root = {w_root[j][ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side <= '0;
            end else begin
                r_side <= w_side[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rad  <= w_rad[j] << 2;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_ad   <= w_ad[j];
        end

        assign w_rad[j+1]  = r_rad;
        assign w_rem[j+1]  = r_rem;
        assign w_root[j+1] = r_root;
        assign w_ad[j+1]   = r_ad;
        assign w_side[j+1] = r_side;
    end

    assign o_root = w_root[ROOT_W];
    assign o_ad   = w_ad[ROOT_W];
    assign o_side = w_side[ROOT_W];
endmodule
`default_nettype wire

// File: design/vang_cordic.sv
// vang_cordic: pipelined vectoring cordic, one micro-rotation per stage
// turns dot magnitude and sine term into an angle in q2.30; depends on vang_pkg
`default_nettype none
module vang_cordic (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [vang_pkg::AD_W-1:0]   i_ad,
    input  wire logic [vang_pkg::ROOT_W-1:0] i_root,
    input  wire vang_pkg::t_side             i_side,
    output logic signed [vang_pkg::Z_W-1:0]  o_z,
    output vang_pkg::t_side                  o_side
);
    import vang_pkg::*;

    logic signed [XY_W-1:0] w_x [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] w_y [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  w_z [CORDIC_STEPS+1];
    t_side                  w_side [CORDIC_STEPS+1];

    assign w_x[0]    = signed'(XY_W'(i_ad));
    assign w_y[0]    = signed'(XY_W'(i_root));
    assign w_z[0]    = '0;
    assign w_side[0] = i_side;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        localparam logic signed [Z_W-1:0] ANG = signed'(Z_W'(atan_q30(i)));
        logic signed [XY_W-1:0] r_x, r_y;
        logic signed [Z_W-1:0]  r_z;
        t_side                  r_side;
        logic signed [XY_W-1:0] xs, ys;

        assign xs = w_x[i] >>> i;
        assign ys = w_y[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side <= '0;
            end else begin
                r_side <= w_side[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_y[i] > 0) begin
                r_x <= w_x[i] + ys;
                r_y <= w_y[i] - xs;
                r_z <= w_z[i] + ANG;
            end else begin
                r_x <= w_x[i] - ys;
                r_y <= w_y[i] + xs;
                r_z <= w_z[i] - ANG;
            end
        end

        assign w_x[i+1]    = r_x;
        assign w_y[i+1]    = r_y;
        assign w_z[i+1]    = r_z;
        assign w_side[i+1] = r_side;
    end

    assign o_z    = w_z[CORDIC_STEPS];
    assign o_side = w_side[CORDIC_STEPS];
endmodule
`default_nettype wire

// File: design/vector_angle_4d.sv
// vector_angle_4d: top level of the 4-component vector angle pipeline
// instantiates vang_front, vang_norm, vang_sqrt and vang_cordic; depends on vang_pkg
//
// usage:
//   a transaction enters when start is high at a rising edge; busy is always low,
//   so a new vector pair may enter in every cycle
//   each transaction gives one result: o_angle (radians, ANGLE_FRAC_BITS fraction
//   bits, 0 to pi) and o_status, shown for one cycle with o_strobe high
//   status: ok, p zero or q zero; a zero vector gives angle 0
//   73 register stages from the input register loaded at the accepting edge to the
//   o_strobe register (6 front stages, 2 scaling stages, 33 square root stages,
//   31 cordic stages, 1 output stage)
//   throughput: one transaction per cycle, set by the fully pipelined datapath
//   reset clears all valid bits; transactions in flight are dropped
//   the receiver cannot stall; results must be taken when o_strobe is high
`default_nettype none
module vector_angle_4d #(
    parameter int COMPONENT_BITS  = 16,
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [COMPONENT_BITS-1:0]  i_p_x0,
    input  wire logic signed [COMPONENT_BITS-1:0]  i_p_x1,
    input  wire logic signed [COMPONENT_BITS-1:0]  i_p_x2,
    input  wire logic signed [COMPONENT_BITS-1:0]  i_p_x3,
    input  wire logic signed [COMPONENT_BITS-1:0]  i_q_x0,
    input  wire logic signed [COMPONENT_BITS-1:0]  i_q_x1,
    input  wire logic signed [COMPONENT_BITS-1:0]  i_q_x2,
    input  wire logic signed [COMPONENT_BITS-1:0]  i_q_x3,
    output logic                                   o_strobe,
    output logic [ANGLE_FRAC_BITS+1:0]             o_angle,
    output logic [1:0]                             o_status
);
    import vang_pkg::*;

    localparam int AW = ANGLE_FRAC_BITS + 2;
    localparam int SH = TURN_FRAC - ANGLE_FRAC_BITS;
    localparam logic [33:0] ROUND     = 34'(1) << (SH - 1);
    localparam logic [AW-1:0] MAX_ANG = AW'((34'(PI_Q30) + ROUND) >> SH);

    logic signed [COMPONENT_BITS-1:0] w_p [4];
    logic signed [COMPONENT_BITS-1:0] w_q [4];

    logic [SUM_W-1:0]       w_sum, w_rad;
    logic [AD_W-1:0]        w_ad_f, w_ad_n, w_ad_s;
    logic [ROOT_W-1:0]      w_root;
    logic signed [Z_W-1:0]  w_z;
    t_side                  w_side_f, w_side_n, w_side_s, w_side_c;

    logic                   r_strobe;
    logic [AW-1:0]          r_angle, n_angle;
    t_status                r_status;

    assign busy = 1'b0;

    assign w_p[0] = i_p_x0;
    assign w_p[1] = i_p_x1;
    assign w_p[2] = i_p_x2;
    assign w_p[3] = i_p_x3;
    assign w_q[0] = i_q_x0;
    assign w_q[1] = i_q_x1;
    assign w_q[2] = i_q_x2;
    assign w_q[3] = i_q_x3;

    vang_front #(.CB(COMPONENT_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_p     (w_p),
        .i_q     (w_q),
        .o_sum   (w_sum),
        .o_ad    (w_ad_f),
        .o_side  (w_side_f)
    );

    vang_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sum   (w_sum),
        .i_ad    (w_ad_f),
        .i_side  (w_side_f),
        .o_rad   (w_rad),
        .o_ad    (w_ad_n),
        .o_side  (w_side_n)
    );

    vang_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rad   (w_rad),
        .i_ad    (w_ad_n),
        .i_side  (w_side_n),
        .o_root  (w_root),
        .o_ad    (w_ad_s),
        .o_side  (w_side_s)
    );

    vang_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ad    (w_ad_s),
        .i_root  (w_root),
        .i_side  (w_side_s),
        .o_z     (w_z),
        .o_side  (w_side_c)
    );

    // clamp to the first quadrant, mirror for a negative dot product, round; a zero vector gives angle 0
    always_comb begin
        logic [Z_W-1:0] zc;
        logic [Z_W-1:0] theta;
        logic [33:0]    sum;
        if (w_z[Z_W-1]) begin
            zc = '0;
        end else if (Z_W'(w_z) > HALF_PI_Q30) begin
            zc = HALF_PI_Q30;
        end else begin
            zc = Z_W'(w_z);
        end
        theta = w_side_c.neg ? PI_Q30 - zc : zc;
        sum   = 34'(theta) + ROUND;
        if (w_side_c.status != ST_OK) begin
            n_angle = '0;
        end else begin
            n_angle = AW'(sum >> SH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_side_c.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_angle  <= n_angle;
        r_status <= w_side_c.status;
    end

    assign o_strobe = r_strobe;
    assign o_angle  = r_angle;
    assign o_status = r_status;

    a_zero_angle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == ST_P_ZERO || o_status == ST_Q_ZERO)) |-> (o_angle == '0))
        else $error("zero vector result with nonzero angle");

    a_no_clamp : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_status != ST_CLAMP))
        else $error("clamp status produced");

    a_angle_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_angle <= MAX_ANG))
        else $error("angle above pi");
endmodule
`default_nettype wire

// File: verif/vector_angle_4d_checker.sv
// vector_angle_4d_checker: watches the input and result channels of vector_angle_4d
// predicts angle and status of every accepted transaction and compares results
// depends on vang_pkg for status codes and cross-term pairs
`timescale 1ns / 1ps
module vector_angle_4d_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic signed [15:0] i_p_x0,
    input  wire logic signed [15:0] i_p_x1,
    input  wire logic signed [15:0] i_p_x2,
    input  wire logic signed [15:0] i_p_x3,
    input  wire logic signed [15:0] i_q_x0,
    input  wire logic signed [15:0] i_q_x1,
    input  wire logic signed [15:0] i_q_x2,
    input  wire logic signed [15:0] i_q_x3,
    input  wire logic               o_strobe,
    input  wire logic [14:0]        o_angle,
    input  wire logic [1:0]         o_status,
    output int                      o_fail_count,
    output int                      o_pending
);
    import vang_pkg::*;

    typedef struct packed {
        logic [14:0] angle;
        t_status     status;
    } t_angle_result;

    localparam longint ARCTAN_STEP [31] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
        64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
        64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
        64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
        64'h00000001
    };
    localparam longint PI_TURN      = 64'd3373259426;
    localparam longint HALF_PI_TURN = 64'd1686629713;

    t_angle_result angle_fifo[$];

    function automatic t_angle_result angle_between(input longint pv[4], input longint qv[4]);
        t_angle_result r;
        longint d, c, m, x, y, z, xs, ys, theta;
        logic [65:0] cross_sq;
        logic [63:0] ad;
        logic [67:0] rem, trial, root;
        bit pz, qz;
        int i;
        pz = 1;
        qz = 1;
        d = 0;
        cross_sq = '0;
        for (i = 0; i < 4; i++) begin
            if (pv[i] != 0) pz = 0;
            if (qv[i] != 0) qz = 0;
        end
        r.angle = '0;
        if (pz || qz) begin
            r.status = pz ? ST_P_ZERO : ST_Q_ZERO;
            return r;
        end
        for (i = 0; i < 4; i++) d += pv[i] * qv[i];
        for (i = 0; i < 6; i++) begin
            c = pv[PAIR_A[i]] * qv[PAIR_B[i]] - pv[PAIR_B[i]] * qv[PAIR_A[i]];
            m = (c < 0) ? -c : c;
            cross_sq += 66'(m * m);
        end
        ad = (d < 0) ? -d : d;
        while (cross_sq < (66'd1 << 62) && ad < (64'd1 << 31)) begin
            cross_sq = cross_sq << 2;
            ad = ad << 1;
        end
        root = '0;
        rem = '0;
        for (i = 32; i >= 0; i--) begin
            rem = (rem << 2) | 68'((cross_sq >> (2 * i)) & 66'd3);
            trial = (root << 2) | 68'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 68'd1;
            end else begin
                root = root << 1;
            end
        end
        x = longint'(ad);
        y = longint'(root);
        z = 0;
        for (i = 0; i < 31; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys;
                y -= xs;
                z += ARCTAN_STEP[i];
            end else begin
                x -= ys;
                y += xs;
                z -= ARCTAN_STEP[i];
            end
        end
        if (z < 0) z = 0;
        if (z > HALF_PI_TURN) z = HALF_PI_TURN;
        theta = (d < 0) ? PI_TURN - z : z;
        r.angle = 15'((theta + (64'd1 << 16)) >> 17);
        r.status = ST_OK;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        t_angle_result want;
        longint pv[4], qv[4];
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (start && !busy) begin
                pv = '{i_p_x0, i_p_x1, i_p_x2, i_p_x3};
                qv = '{i_q_x0, i_q_x1, i_q_x2, i_q_x3};
                angle_fifo.push_back(angle_between(pv, qv));
            end
            if (o_strobe) begin
                if (angle_fifo.size() == 0) begin
                    $display("%0t: unexpected result angle %0d status %0d",
                             $time, o_angle, o_status);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = angle_fifo.pop_front();
                    if (o_angle !== want.angle || o_status !== want.status) begin
                        $display("%0t: mismatch expected angle %0d status %0d, actual angle %0d status %0d",
                                 $time, want.angle, want.status, o_angle, o_status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= angle_fifo.size();
    end
endmodule

// File: verif/tb_vector_angle_4d.sv
// tb_vector_angle_4d: stimulus and verdict for vector_angle_4d
// directed vector pairs then random ones with random start gaps; checking in the checker
// depends on vector_angle_4d, vector_angle_4d_checker and vang_pkg
`timescale 1ns / 1ps
module tb_vector_angle_4d;
    logic i_clk = 0;
    logic i_rst_n = 0;
    logic start = 0;
    logic busy;
    logic signed [15:0] p0 = 0, p1 = 0, p2 = 0, p3 = 0, q0 = 0, q1 = 0, q2 = 0, q3 = 0;
    logic o_strobe;
    logic [14:0] o_angle;
    logic [1:0] o_status;
    int fail_count, pending;
    int cycles = 0;

    vector_angle_4d dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_p_x0(p0), .i_p_x1(p1), .i_p_x2(p2), .i_p_x3(p3),
        .i_q_x0(q0), .i_q_x1(q1), .i_q_x2(q2), .i_q_x3(q3),
        .o_strobe(o_strobe), .o_angle(o_angle), .o_status(o_status)
    );

    vector_angle_4d_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_p_x0(p0), .i_p_x1(p1), .i_p_x2(p2), .i_p_x3(p3),
        .i_q_x0(q0), .i_q_x1(q1), .i_q_x2(q2), .i_q_x3(q3),
        .o_strobe(o_strobe), .o_angle(o_angle), .o_status(o_status),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 200000) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_pair(input logic signed [15:0] a0, a1, a2, a3, b0, b1, b2, b3);
        p0 <= a0; p1 <= a1; p2 <= a2; p3 <= a3;
        q0 <= b0; q1 <= b1; q2 <= b2; q3 <= b3;
        start <= 1;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic maybe_idle(input bit allow);
        if (allow && $urandom_range(0, 3) == 0) begin
            start <= 0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [15:0] rand_comp(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 16)) - 8);
            default: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        endcase
    endfunction

    initial begin
        logic signed [15:0] a[4], b[4];
        int k, n, mode, kind;
        bit ok;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // zero vectors, extremes, parallel, antiparallel, orthogonal
        send_pair(0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(0, 0, 0, 0, 1, 2, 3, 4);
        send_pair(5, 0, 0, 0, 0, 0, 0, 0);
        send_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        send_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        send_pair(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768);
        send_pair(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767);
        send_pair(1, 0, 0, 0, 0, 1, 0, 0);
        send_pair(0, 0, 0, 1, 0, 0, 1, 0);
        send_pair(1, 2, 3, 4, 2, 4, 6, 8);
        send_pair(1, 2, 3, 4, -3, -6, -9, -12);
        send_pair(1, 0, 0, 0, 1, 1, 0, 0);
        send_pair(1, 0, 0, 0, -1, 1, 0, 0);
        send_pair(-32768, 0, 0, 0, 0, 0, 0, 32767);
        send_pair(1, 0, 0, 0, 32767, 1, 0, 0);
        send_pair(32767, -32768, 1, -1, -1, 1, 32767, -32768);
        maybe_idle(1);
        send_pair(0, 0, 0, 0, -32768, 0, 0, 0);
        send_pair(0, 0, 0, 0, 0, 0, 0, 0);

        for (n = 0; n < 500; n++) begin
            kind = $urandom_range(0, 19);
            for (k = 0; k < 4; k++) begin
                mode = (kind < 12) ? 0 : (kind < 15) ? 1 : (kind == 15) ? 2 : 0;
                a[k] = rand_comp(mode);
                b[k] = rand_comp(mode);
            end
            if (kind == 16) for (k = 0; k < 4; k++) b[k] = $urandom_range(0, 1) ? a[k] : -a[k];
            if (kind == 17) begin
                for (k = 0; k < 4; k++) a[k] = rand_comp(1);
                mode = $urandom_range(0, 1) ? 3 : -2;
                for (k = 0; k < 4; k++) b[k] = a[k] * mode;
            end
            if (kind == 18) for (k = 0; k < 4; k++) a[k] = 0;
            if (kind == 19) for (k = 0; k < 4; k++) b[k] = 0;
            send_pair(a[0], a[1], a[2], a[3], b[0], b[1], b[2], b[3]);
            maybe_idle(n < 420);
        end
        start <= 0;

        ok = 0;
        for (k = 0; k < 2000 && !ok; k++) begin
            @(posedge i_clk);
            if (pending == 0) ok = 1;
        end
        repeat (80) @(posedge i_clk);
        if (ok && fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
